>>> sv/abl_momentum_source_terms_assert.svh
// Assertion macros for the momentum source-term block.
// Both forms sample on the rising clock edge.
`ifndef ABL_MOMENTUM_SOURCE_TERMS_ASSERT_SVH
`define ABL_MOMENTUM_SOURCE_TERMS_ASSERT_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define ABL_MST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define ABL_MST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABL_MST_ASSERT(lbl, clk, rst, prop, msg)
`define ABL_MST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/abl_mst_pkg.sv
package abl_mst_pkg;

   // datapath word, Q16.16 values and Q4.28 gains
   localparam int DATA_WIDTH = 32;
   localparam int GAIN_FRAC  = 28;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);
   localparam int NUM_STAGES = 9;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int RND_WIDTH  = PROD_WIDTH + 1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic [RND_WIDTH-1:0]         rnd_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   // half an LSB of the Q.16 result, seen in the Q.44 product
   localparam rnd_type  RND_HALF = rnd_type'(1) << (GAIN_FRAC - 1);

   // configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUOY_GAIN_X = 3'd0,
      CSR_BUOY_GAIN_Y = 3'd1,
      CSR_BUOY_GAIN_Z = 3'd2,
      CSR_REF_TEMP    = 3'd3,
      CSR_COR_SIN     = 3'd4,
      CSR_COR_COS     = 3'd5,
      CSR_FORCING_U   = 3'd6,
      CSR_FORCING_V   = 3'd7
   } csr_reg_type;

   // pipeline control: per-stage load enables and occupancy
   typedef struct packed {
      logic [NUM_STAGES-1:0] adv;
      logic [NUM_STAGES-1:0] vld;
   } pipe_ctl_type;

   // saturating add
   function automatic data_type sat_add(data_type a, data_type b);
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end
      return data_type'(s[DATA_WIDTH-1:0]);
   endfunction

   // saturating subtract
   function automatic data_type sat_sub(data_type a, data_type b);
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end
      return data_type'(s[DATA_WIDTH-1:0]);
   endfunction

endpackage

>>> sv/abl_momentum_source_terms.sv
// Channel | Direction | Beat contents
// req_    | in        | vel_x, vel_y, vel_z, temperature (Q16.16)
// rsp_    | out       | new_vel_x, new_vel_y, new_vel_z (Q16.16, saturated)
// csr_    | in        | write enable, register index, write data
//
// Nine register stages: temperature difference, buoyancy multiply and round,
// buoyancy add, Coriolis multiply and round, then three saturating adds.
// One beat per cycle is accepted while the pipe is not full and stalled;
// its result leaves from the last stage register.
// Reset clears the occupancy bits and all configuration registers to zero.
// An output stall holds the last stage; the earlier stages keep filling
// empty slots, so the input stays ready until the pipe is full.
`include "abl_momentum_source_terms_assert.svh"

module abl_momentum_source_terms (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  abl_mst_pkg::data_type                  req_vel_x,
   input  abl_mst_pkg::data_type                  req_vel_y,
   input  abl_mst_pkg::data_type                  req_vel_z,
   input  abl_mst_pkg::data_type                  req_temperature,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output abl_mst_pkg::data_type                  rsp_new_vel_x,
   output abl_mst_pkg::data_type                  rsp_new_vel_y,
   output abl_mst_pkg::data_type                  rsp_new_vel_z,
   input  logic                                   csr_we,
   input  logic [abl_mst_pkg::CSR_IDX_W-1:0]      csr_index,
   input  abl_mst_pkg::data_type                  csr_wdata
);

   // stage numbers
   localparam int ST_DIFF = 0;
   localparam int ST_BMUL = 1;
   localparam int ST_BRND = 2;
   localparam int ST_BADD = 3;
   localparam int ST_CMUL = 4;
   localparam int ST_CRND = 5;
   localparam int ST_CROT = 6;
   localparam int ST_SUM1 = 7;
   localparam int ST_OUT  = 8;

   abl_mst_pkg::pipe_ctl_type pipe_ctl;

   abl_mst_pkg::data_type gain_x_ff, gain_y_ff, gain_z_ff, ref_temp_ff;
   abl_mst_pkg::data_type cor_sin_ff, cor_cos_ff, force_u_ff, force_v_ff;

   abl_mst_pkg::data_type x1_ff, y1_ff, z1_ff, diff1_ff, diff1_in;
   abl_mst_pkg::data_type x2_ff, y2_ff, z2_ff;
   abl_mst_pkg::data_type x3_ff, y3_ff, z3_ff;
   abl_mst_pkg::data_type bx3, by3, bz3;
   abl_mst_pkg::data_type x4_ff, y4_ff, z4_ff, x4_in, y4_in, z4_in;
   abl_mst_pkg::data_type x5_ff, y5_ff, z5_ff;
   abl_mst_pkg::data_type x6_ff, y6_ff, z6_ff;
   abl_mst_pkg::data_type sy6, sx6, cz6;
   abl_mst_pkg::data_type x7_ff, y7_ff, z7_ff, cz7_ff, x7_in, y7_in;
   abl_mst_pkg::data_type x8_ff, y8_ff, z8_ff, x8_in, y8_in;
   abl_mst_pkg::data_type x9_ff, y9_ff, z9_ff, x9_in;

   // handshake and stage enables
   abl_mst_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .pipe_ctl  (pipe_ctl)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff   <= '0;
         gain_y_ff   <= '0;
         gain_z_ff   <= '0;
         ref_temp_ff <= '0;
         cor_sin_ff  <= '0;
         cor_cos_ff  <= '0;
         force_u_ff  <= '0;
         force_v_ff  <= '0;
      end else if (csr_we) begin
         unique case (abl_mst_pkg::csr_reg_type'(csr_index))
            abl_mst_pkg::CSR_BUOY_GAIN_X: gain_x_ff   <= csr_wdata;
            abl_mst_pkg::CSR_BUOY_GAIN_Y: gain_y_ff   <= csr_wdata;
            abl_mst_pkg::CSR_BUOY_GAIN_Z: gain_z_ff   <= csr_wdata;
            abl_mst_pkg::CSR_REF_TEMP:    ref_temp_ff <= csr_wdata;
            abl_mst_pkg::CSR_COR_SIN:     cor_sin_ff  <= csr_wdata;
            abl_mst_pkg::CSR_COR_COS:     cor_cos_ff  <= csr_wdata;
            abl_mst_pkg::CSR_FORCING_U:   force_u_ff  <= csr_wdata;
            abl_mst_pkg::CSR_FORCING_V:   force_v_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // T0 - T
   assign diff1_in = abl_mst_pkg::sat_sub(ref_temp_ff, req_temperature);

   // buoyancy products
   abl_mst_gmul u_buoy_x (
      .clock (clock), .mul_en (pipe_ctl.adv[ST_BMUL]), .rnd_en (pipe_ctl.adv[ST_BRND]),
      .gain  (gain_x_ff), .value (diff1_ff), .result (bx3)
   );
   abl_mst_gmul u_buoy_y (
      .clock (clock), .mul_en (pipe_ctl.adv[ST_BMUL]), .rnd_en (pipe_ctl.adv[ST_BRND]),
      .gain  (gain_y_ff), .value (diff1_ff), .result (by3)
   );
   abl_mst_gmul u_buoy_z (
      .clock (clock), .mul_en (pipe_ctl.adv[ST_BMUL]), .rnd_en (pipe_ctl.adv[ST_BRND]),
      .gain  (gain_z_ff), .value (diff1_ff), .result (bz3)
   );

   // velocities after buoyancy
   assign x4_in = abl_mst_pkg::sat_add(x3_ff, bx3);
   assign y4_in = abl_mst_pkg::sat_add(y3_ff, by3);
   assign z4_in = abl_mst_pkg::sat_add(z3_ff, bz3);

   // Coriolis products, all from post-buoyancy velocities
   abl_mst_gmul u_cor_sy (
      .clock (clock), .mul_en (pipe_ctl.adv[ST_CMUL]), .rnd_en (pipe_ctl.adv[ST_CRND]),
      .gain  (cor_sin_ff), .value (y4_ff), .result (sy6)
   );
   abl_mst_gmul u_cor_sx (
      .clock (clock), .mul_en (pipe_ctl.adv[ST_CMUL]), .rnd_en (pipe_ctl.adv[ST_CRND]),
      .gain  (cor_sin_ff), .value (x4_ff), .result (sx6)
   );
   abl_mst_gmul u_cor_cz (
      .clock (clock), .mul_en (pipe_ctl.adv[ST_CMUL]), .rnd_en (pipe_ctl.adv[ST_CRND]),
      .gain  (cor_cos_ff), .value (z4_ff), .result (cz6)
   );

   // x - s*y and y + s*x, then + c*z and forcing, one add per stage
   assign x7_in = abl_mst_pkg::sat_sub(x6_ff, sy6);
   assign y7_in = abl_mst_pkg::sat_add(y6_ff, sx6);
   assign x8_in = abl_mst_pkg::sat_add(x7_ff, cz7_ff);
   assign y8_in = abl_mst_pkg::sat_add(y7_ff, force_v_ff);
   assign x9_in = abl_mst_pkg::sat_add(x8_ff, force_u_ff);

   // datapath registers
   always_ff @(posedge clock) begin
      if (pipe_ctl.adv[ST_DIFF]) begin
         x1_ff    <= req_vel_x;
         y1_ff    <= req_vel_y;
         z1_ff    <= req_vel_z;
         diff1_ff <= diff1_in;
      end
      if (pipe_ctl.adv[ST_BMUL]) begin
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;
      end
      if (pipe_ctl.adv[ST_BRND]) begin
         x3_ff <= x2_ff;
         y3_ff <= y2_ff;
         z3_ff <= z2_ff;
      end
      if (pipe_ctl.adv[ST_BADD]) begin
         x4_ff <= x4_in;
         y4_ff <= y4_in;
         z4_ff <= z4_in;
      end
      if (pipe_ctl.adv[ST_CMUL]) begin
         x5_ff <= x4_ff;
         y5_ff <= y4_ff;
         z5_ff <= z4_ff;
      end
      if (pipe_ctl.adv[ST_CRND]) begin
         x6_ff <= x5_ff;
         y6_ff <= y5_ff;
         z6_ff <= z5_ff;
      end
      if (pipe_ctl.adv[ST_CROT]) begin
         x7_ff  <= x7_in;
         y7_ff  <= y7_in;
         z7_ff  <= z6_ff;
         cz7_ff <= cz6;
      end
      if (pipe_ctl.adv[ST_SUM1]) begin
         x8_ff <= x8_in;
         y8_ff <= y8_in;
         z8_ff <= z7_ff;
      end
      if (pipe_ctl.adv[ST_OUT]) begin
         x9_ff <= x9_in;
         y9_ff <= y8_ff;
         z9_ff <= z8_ff;
      end
   end

   assign rsp_new_vel_x = x9_ff;
   assign rsp_new_vel_y = y9_ff;
   assign rsp_new_vel_z = z9_ff;

   // an open output lets every stage move
   `ABL_MST_ASSERT_ALWAYS(a_ready_when_drained, clock, rsp_ready |-> req_ready, "input stalled while output drains")
   // an accepted beat lands in the first stage
   `ABL_MST_ASSERT(a_accept_fills_first, clock, reset, (req_valid && req_ready) |=> pipe_ctl.vld[ST_DIFF], "accepted beat lost at entry")
   // a full pipe with a stalled output takes nothing
   `ABL_MST_ASSERT(a_full_blocks_input, clock, reset, ((&pipe_ctl.vld) && !rsp_ready) |-> !req_ready, "input open while pipe full and stalled")

endmodule

>>> sv/abl_mst_ctl.sv
// Valid/ready chain for the datapath: a stage loads when it is empty or
// when the stage after it moves on, so bubbles are squeezed out.
module abl_mst_ctl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output abl_mst_pkg::pipe_ctl_type   pipe_ctl
);

   logic [abl_mst_pkg::NUM_STAGES-1:0] valid_ff;
   logic [abl_mst_pkg::NUM_STAGES-1:0] valid_in;
   logic [abl_mst_pkg::NUM_STAGES-1:0] adv;

   // load enables, from the output side back
   always_comb begin
      adv[abl_mst_pkg::NUM_STAGES-1] = ~valid_ff[abl_mst_pkg::NUM_STAGES-1] | rsp_ready;
      for (int i = abl_mst_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = ~valid_ff[i] | adv[i+1];
      end
   end

   // occupancy moves with the data
   always_comb begin
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < abl_mst_pkg::NUM_STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready    = adv[0];
   assign rsp_valid    = valid_ff[abl_mst_pkg::NUM_STAGES-1];
   assign pipe_ctl.adv = adv;
   assign pipe_ctl.vld = valid_ff;

endmodule

>>> sv/abl_mst_gmul.sv
// Gain times value: signed product in one stage, round half up to Q.16
// and saturate in the next.
module abl_mst_gmul (
   input  logic                   clock,
   input  logic                   mul_en,
   input  logic                   rnd_en,
   input  abl_mst_pkg::data_type  gain,
   input  abl_mst_pkg::data_type  value,
   output abl_mst_pkg::data_type  result
);

   abl_mst_pkg::prod_type prod_ff;
   abl_mst_pkg::prod_type prod_in;
   abl_mst_pkg::rnd_type  rnd_sum;
   logic signed [abl_mst_pkg::RND_WIDTH-1:0] rnd_shift;
   logic [abl_mst_pkg::RND_WIDTH-abl_mst_pkg::DATA_WIDTH:0] rnd_top;
   abl_mst_pkg::data_type res_ff;
   abl_mst_pkg::data_type res_in;

   // full-width product, exact
   assign prod_in = abl_mst_pkg::prod_type'(gain) * abl_mst_pkg::prod_type'(value);

   // round, drop fraction bits, clamp to the word
   always_comb begin
      rnd_sum   = {prod_ff[abl_mst_pkg::PROD_WIDTH-1], prod_ff} + abl_mst_pkg::RND_HALF;
      rnd_shift = $signed(rnd_sum) >>> abl_mst_pkg::GAIN_FRAC;
      rnd_top   = rnd_shift[abl_mst_pkg::RND_WIDTH-1:abl_mst_pkg::DATA_WIDTH-1];
      if ((&rnd_top) || ~(|rnd_top)) begin
         res_in = abl_mst_pkg::data_type'(rnd_shift[abl_mst_pkg::DATA_WIDTH-1:0]);
      end else begin
         res_in = rnd_shift[abl_mst_pkg::RND_WIDTH-1] ? abl_mst_pkg::DATA_MIN
                                                       : abl_mst_pkg::DATA_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (rnd_en) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule
